[rtl/mcc_pkg.sv]
// Shared constants, register indexes, state codes and control structs for the coin change block.
package mcc_pkg;

  // Fixed field widths
  localparam int AMT_W      = 10;
  localparam int CNT_W      = 10;
  localparam int IDX_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Number of coin value registers, and the largest amount the input field can carry
  localparam int COIN_REGS = 6;
  localparam int AMT_MAX   = 1023;

  // Defaults for the top level parameters
  localparam int MAX_COINS_DEF  = 6;
  localparam int MAX_AMOUNT_DEF = 1023;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COINS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_5 = 3'd6;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ISSUE,
    ST_LAST,
    ST_LOOKUP,
    ST_LATCH,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic write_row;
    logic lookup;
    logic latch;
    logic out_next;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic need_ext;
    logic coin_last;
    logic row_done;
    logic out_last;
  } sts_t;

endpackage

[rtl/mcc_ctrl.sv]
// Controller state machine: sequences table extension, lookup and result output.
module mcc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  mcc_pkg::sts_t  sts,
  output mcc_pkg::cmd_t  cmd
);

  mcc_pkg::state_t state;
  mcc_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mcc_pkg::ST_IDLE: begin
        if (in_valid) state_next = mcc_pkg::ST_CHECK;
      end
      mcc_pkg::ST_CHECK: begin
        // Build missing rows first, or go straight to the table read.
        state_next = sts.need_ext ? mcc_pkg::ST_ISSUE : mcc_pkg::ST_LOOKUP;
      end
      mcc_pkg::ST_ISSUE: begin
        if (sts.coin_last) state_next = mcc_pkg::ST_LAST;
      end
      mcc_pkg::ST_LAST: begin
        state_next = sts.row_done ? mcc_pkg::ST_LOOKUP : mcc_pkg::ST_ISSUE;
      end
      mcc_pkg::ST_LOOKUP: begin
        state_next = mcc_pkg::ST_LATCH;
      end
      mcc_pkg::ST_LATCH: begin
        state_next = mcc_pkg::ST_EMIT;
      end
      mcc_pkg::ST_EMIT: begin
        if (!out_stall && sts.out_last) state_next = mcc_pkg::ST_IDLE;
      end
      default: begin
        state_next = mcc_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state)
      mcc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      mcc_pkg::ST_ISSUE: begin
        cmd.issue = 1'b1;
      end
      mcc_pkg::ST_LAST: begin
        cmd.write_row = 1'b1;
      end
      mcc_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      mcc_pkg::ST_LATCH: begin
        cmd.latch = 1'b1;
      end
      mcc_pkg::ST_EMIT: begin
        out_valid    = 1'b1;
        cmd.out_next = !out_stall;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[rtl/mcc_datapath.sv]
// Datapath: configuration registers, count table memory, best-row compare and result register.
module mcc_datapath #(
  parameter int MAX_COINS  = mcc_pkg::MAX_COINS_DEF,
  parameter int MAX_AMOUNT = mcc_pkg::MAX_AMOUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [mcc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [mcc_pkg::CFG_DATA_W-1:0]  wr_data,
  input  logic [mcc_pkg::AMT_W-1:0]       amount,
  input  mcc_pkg::cmd_t                   cmd,
  output mcc_pkg::sts_t                   sts,
  output logic [mcc_pkg::IDX_W-1:0]       coin_index,
  output logic [mcc_pkg::CNT_W-1:0]       coin_count,
  output logic                            reachable,
  output logic                            last
);

  localparam int LANES  = (MAX_COINS < mcc_pkg::COIN_REGS) ? MAX_COINS : mcc_pkg::COIN_REGS;
  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int LIMIT  = (MAX_AMOUNT < mcc_pkg::AMT_MAX) ? MAX_AMOUNT : mcc_pkg::AMT_MAX;
  localparam int DEPTH  = LIMIT + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [mcc_pkg::AMT_W-1:0] AMT_LIMIT = mcc_pkg::AMT_W'(LIMIT);
  localparam logic [mcc_pkg::IDX_W-1:0] LANES_N   = mcc_pkg::IDX_W'(LANES);

  // One table row: reachable flag, coin total and a count for each lane
  typedef struct packed {
    logic                                 ok;
    logic [mcc_pkg::CNT_W-1:0]            tot;
    logic [LANES-1:0][mcc_pkg::CNT_W-1:0] cnt;
  } row_t;

  row_t mem [DEPTH];

  // Configuration
  logic [mcc_pkg::IDX_W-1:0] num_coins;
  logic [mcc_pkg::CNT_W-1:0] coin_value [LANES];

  // Control state
  logic [ADDR_W-1:0] filled;
  logic              pend;

  // Working registers
  logic [mcc_pkg::AMT_W-1:0]            amt;
  logic [ADDR_W-1:0]                    row;
  logic [LANE_W-1:0]                    cj;
  logic [LANE_W-1:0]                    ej;
  logic [LANE_W-1:0]                    oj;
  logic                                 use_q;
  logic                                 zero_q;
  row_t                                 rd_q;
  row_t                                 best;
  logic                                 res_ok;
  logic [LANES-1:0][mcc_pkg::CNT_W-1:0] res_cnt;

  // Combinational values
  logic [mcc_pkg::IDX_W-1:0] n_use;
  logic [mcc_pkg::IDX_W-1:0] n_last;
  logic [mcc_pkg::CNT_W-1:0] cur_v;
  logic                      usable;
  logic [ADDR_W-1:0]         p_addr;
  logic [ADDR_W-1:0]         rd_addr;
  logic                      rd_zero;
  logic                      in_range;
  logic                      prev_ok;
  row_t                      prev;
  row_t                      cand;
  logic [mcc_pkg::CNT_W:0]   cand_tot;
  logic                      take;
  row_t                      best_next;
  logic                      lookup_ok;

  // Coins in use: zero acts as one, and no more than the lanes built
  always_comb begin
    if (num_coins == '0) begin
      n_use = mcc_pkg::IDX_W'(1);
    end else if (num_coins > LANES_N) begin
      n_use = LANES_N;
    end else begin
      n_use = num_coins;
    end
    n_last = n_use - mcc_pkg::IDX_W'(1);
  end

  // Read address: the row one coin below the current row, or the requested amount
  always_comb begin
    cur_v    = coin_value[cj];
    usable   = (cur_v != '0) && (cur_v <= mcc_pkg::AMT_W'(row));
    p_addr   = row - ADDR_W'(cur_v);
    rd_addr  = cmd.lookup ? ADDR_W'(amt) : p_addr;
    rd_zero  = (rd_addr == '0);
    in_range = (amt <= AMT_LIMIT);
  end

  // Candidate from the row just read; row zero is all zeros and reachable.
  // A strictly smaller total is needed, so the coin issued first (lower lane index) keeps a tie.
  always_comb begin
    prev     = zero_q ? '0 : rd_q;
    prev_ok  = zero_q || rd_q.ok;
    cand_tot = {1'b0, prev.tot} + 1'b1;
    cand     = prev;
    cand.ok  = 1'b1;
    cand.tot = cand_tot[mcc_pkg::CNT_W-1:0];
    cand.cnt[ej] = prev.cnt[ej] + 1'b1;
    take = pend && use_q && prev_ok && (!best.ok || (cand_tot < {1'b0, best.tot}));
    best_next = take ? cand : best;
    lookup_ok = in_range && (zero_q || rd_q.ok);
  end

  // Status to the controller
  always_comb begin
    sts.need_ext  = in_range && (amt > mcc_pkg::AMT_W'(filled));
    sts.coin_last = (mcc_pkg::IDX_W'(cj) == n_last);
    sts.row_done  = (mcc_pkg::AMT_W'(row) == amt);
    sts.out_last  = (mcc_pkg::IDX_W'(oj) == n_last);
  end

  // Result word
  assign coin_index = mcc_pkg::IDX_W'(oj);
  assign coin_count = res_cnt[oj];
  assign reachable  = res_ok;
  assign last       = sts.out_last;

  // Configuration registers and high-water mark; any register write drops the table
  always_ff @(posedge clk) begin
    if (rst) begin
      num_coins <= mcc_pkg::IDX_W'(1);
      for (int l = 0; l < LANES; l++) begin
        coin_value[l] <= mcc_pkg::CNT_W'(1);
      end
      filled <= '0;
      pend   <= 1'b0;
    end else begin
      pend <= cmd.issue;
      if (wr_en && (wr_index <= mcc_pkg::REG_COIN_VALUE_5)) begin
        filled <= '0;
      end else if (cmd.write_row) begin
        filled <= row;
      end
      if (wr_en) begin
        if (wr_index == mcc_pkg::REG_NUM_COINS) begin
          num_coins <= wr_data[mcc_pkg::IDX_W-1:0];
        end
        for (int l = 0; l < LANES; l++) begin
          if (wr_index == mcc_pkg::CFG_IDX_W'(mcc_pkg::REG_COIN_VALUE_0 + l)) begin
            coin_value[l] <= wr_data;
          end
        end
      end
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.write_row) begin
      mem[row] <= best_next;
    end
    if (cmd.issue || cmd.lookup) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Row build and lookup registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      amt  <= amount;
      row  <= filled + 1'b1;
      cj   <= '0;
      best <= '0;
    end
    if (cmd.issue) begin
      use_q  <= usable;
      zero_q <= rd_zero;
      ej     <= cj;
      cj     <= sts.coin_last ? '0 : cj + 1'b1;
    end
    if (cmd.lookup) begin
      zero_q <= rd_zero;
    end
    if (cmd.write_row) begin
      best <= '0;
      row  <= row + 1'b1;
    end else if (pend) begin
      best <= best_next;
    end
    if (cmd.latch) begin
      res_ok  <= lookup_ok;
      res_cnt <= (lookup_ok && !zero_q) ? rd_q.cnt : '0;
      oj      <= '0;
    end
    if (cmd.out_next) begin
      oj <= oj + 1'b1;
    end
  end

endmodule

[rtl/min_coin_change_table.sv]
// Top level of the minimum coin change table: controller and datapath.
//
//   channel  direction  handshake               payload
//   input    in         in_valid / in_stall     amount
//   output   out        out_valid / out_stall   coin_index, coin_count, reachable, last
//   config   in         wr_en                   wr_index, wr_data
//
// An amount whose row is already known goes through the lookup and latch states, then its
// output words follow in order. Each new row of the table is built one coin per cycle through
// the single read port of the table memory and is then written in the last state.
// Reset returns the controller to idle with an empty table.
// in_stall stays high from acceptance until the last word of the item has been taken;
// out_stall holds the current word and the controller in place.
module min_coin_change_table #(
  parameter int MAX_COINS  = mcc_pkg::MAX_COINS_DEF,
  parameter int MAX_AMOUNT = mcc_pkg::MAX_AMOUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [mcc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [mcc_pkg::CFG_DATA_W-1:0]  wr_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mcc_pkg::AMT_W-1:0]       amount,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mcc_pkg::IDX_W-1:0]       coin_index,
  output logic [mcc_pkg::CNT_W-1:0]       coin_count,
  output logic                            reachable,
  output logic                            last
);

  mcc_pkg::cmd_t cmd;
  mcc_pkg::sts_t sts;

  // Sequencer
  mcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table, compare and result registers
  mcc_datapath #(
    .MAX_COINS  (MAX_COINS),
    .MAX_AMOUNT (MAX_AMOUNT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .amount     (amount),
    .cmd        (cmd),
    .sts        (sts),
    .coin_index (coin_index),
    .coin_count (coin_count),
    .reachable  (reachable),
    .last       (last)
  );

endmodule
